/* design/dda_pkg.sv */
package dda_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int QUOT_W = FRAC_BITS + 1;
  localparam int STEP_W = QUOT_W + 1;
  localparam int REM_W  = COORD_BITS + 1;
  localparam int CNT_W  = $clog2(QUOT_W);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_NEXT = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] mag;
    logic [COORD_BITS-1:0] divisor;
  } dda_div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } dda_div_rsp_t;

  // floor(p + 0.5), clamped at zero, wrapped to the coordinate range
  function automatic logic [COORD_BITS-1:0] round_pos(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] sum;
    sum = p + (POS_W'(1) << (FRAC_BITS - 1));
    if (p[POS_W-1]) begin
      return '0;
    end
    return sum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
  endfunction

endpackage

/* design/dda_div.sv */
module dda_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dda_pkg::dda_div_req_t req,
  output dda_pkg::dda_div_rsp_t rsp
);
  import dda_pkg::*;

  // restoring division, one quotient bit per cycle: mag * 2^FRAC_BITS / divisor
  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [QUOT_W-1:0]     quot_r, quot_nxt;
  logic [COORD_BITS-1:0] div_r, div_nxt;
  logic                  done_r, done_nxt;
  logic [REM_W-1:0]      diff;
  logic                  ge;
  logic [REM_W-1:0]      kept;

  always_comb begin
    diff     = rem_r - {1'b0, div_r};
    ge       = rem_r >= {1'b0, div_r};
    kept     = ge ? diff : rem_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUOT_W - 1);
      rem_nxt  = {1'b0, req.mag};
      quot_nxt = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = {kept[REM_W-2:0], 1'b0};
      quot_nxt = {quot_r[QUOT_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    div_r  <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

/* design/dda_line_rasterizer_unit.sv */
// DDA line rasterizer.
// Input channel (in_valid/in_ready): in_func = 0 loads a line from
// in_start_x/y to in_end_x/y, in_func = 1 asks for the next point.
// Output channel (out_valid/out_ready): one point per transaction, rounded
// to the nearest pixel, out_last marking the final endpoint.
// A load produces the start point in the next cycle, then computes the two
// per-axis increments on one shared restoring divider, one bit per cycle,
// x first and then y; in_ready stays low until both are done.
// A degenerate line (equal endpoints) gives one point with out_last set and
// needs no division.
// Each next-point transaction gives its point in the next cycle; with the
// receiver ready, points flow at one per cycle. A next-point request with no
// line in progress is taken and gives nothing.
// The single output register holds a point until taken; in_ready is low
// while it is full and out_ready is low.
// Reset (synchronous, rst_n low) leaves the block idle with no line active.
module dda_line_rasterizer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [dda_pkg::COORD_BITS-1:0]  in_start_x,
  input  logic [dda_pkg::COORD_BITS-1:0]  in_start_y,
  input  logic [dda_pkg::COORD_BITS-1:0]  in_end_x,
  input  logic [dda_pkg::COORD_BITS-1:0]  in_end_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dda_pkg::COORD_BITS-1:0]  out_point_x,
  output logic [dda_pkg::COORD_BITS-1:0]  out_point_y,
  output logic                            out_last
);
  import dda_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } state_t;

  state_t                state_r, state_nxt;
  logic [POS_W-1:0]      pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]      pos_y_r, pos_y_nxt;
  logic [STEP_W-1:0]     step_x_r, step_x_nxt;
  logic [STEP_W-1:0]     step_y_r, step_y_nxt;
  logic [COORD_BITS-1:0] steps_left_r, steps_left_nxt;
  logic                  active_r, active_nxt;
  logic                  neg_x_r, neg_x_nxt;
  logic                  neg_y_r, neg_y_nxt;
  logic [COORD_BITS-1:0] ady_r, ady_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_x_nxt;
  logic [COORD_BITS-1:0] out_y_r, out_y_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_fire;
  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0] adx, ady, steps;
  logic [POS_W-1:0]      adv_x, adv_y;
  logic [STEP_W-1:0]     q_pos, q_neg;
  dda_div_req_t          div_req;
  dda_div_rsp_t          div_rsp;

  dda_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    dx    = {1'b0, in_end_x} - {1'b0, in_start_x};
    dy    = {1'b0, in_end_y} - {1'b0, in_start_y};
    adx   = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady   = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    steps = (adx > ady) ? adx : ady;
    adv_x = pos_x_r + {{(POS_W-STEP_W){step_x_r[STEP_W-1]}}, step_x_r};
    adv_y = pos_y_r + {{(POS_W-STEP_W){step_y_r[STEP_W-1]}}, step_y_r};
    q_pos = {1'b0, div_rsp.quot};
    q_neg = -q_pos;

    state_nxt      = state_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    step_x_nxt     = step_x_r;
    step_y_nxt     = step_y_r;
    steps_left_nxt = steps_left_r;
    active_nxt     = active_r;
    neg_x_nxt      = neg_x_r;
    neg_y_nxt      = neg_y_r;
    ady_nxt        = ady_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_last_nxt   = out_last_r;
    div_req.start   = 1'b0;
    div_req.mag     = adx;
    div_req.divisor = steps;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_LOAD) begin
            pos_x_nxt      = {1'b0, in_start_x, {FRAC_BITS{1'b0}}};
            pos_y_nxt      = {1'b0, in_start_y, {FRAC_BITS{1'b0}}};
            step_x_nxt     = '0;
            step_y_nxt     = '0;
            steps_left_nxt = steps;
            active_nxt     = 1'b0;
            neg_x_nxt      = dx[COORD_BITS];
            neg_y_nxt      = dy[COORD_BITS];
            ady_nxt        = ady;
            out_valid_nxt  = 1'b1;
            out_x_nxt      = in_start_x;
            out_y_nxt      = in_start_y;
            out_last_nxt   = (steps == '0);
            if (steps != '0) begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV_X;
            end
          end else if (active_r) begin
            pos_x_nxt      = adv_x;
            pos_y_nxt      = adv_y;
            steps_left_nxt = steps_left_r - COORD_BITS'(1);
            active_nxt     = (steps_left_r != COORD_BITS'(1));
            out_valid_nxt  = 1'b1;
            out_x_nxt      = round_pos(adv_x);
            out_y_nxt      = round_pos(adv_y);
            out_last_nxt   = (steps_left_r == COORD_BITS'(1));
          end
        end
      end
      ST_DIV_X: begin
        div_req.mag     = ady_r;
        div_req.divisor = steps_left_r;
        if (div_rsp.done) begin
          step_x_nxt    = neg_x_r ? q_neg : q_pos;
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_rsp.done) begin
          step_y_nxt = neg_y_r ? q_neg : q_pos;
          active_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      step_x_r     <= '0;
      step_y_r     <= '0;
      steps_left_r <= '0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
      step_x_r     <= step_x_nxt;
      step_y_r     <= step_y_nxt;
      steps_left_r <= steps_left_nxt;
      active_r     <= active_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    ady_r      <= ady_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;
  assign out_last    = out_last_r;

endmodule

/* bench/dda_line_rasterizer_unit_tb.sv */
module dda_line_rasterizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dda_pkg::*;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  typedef struct {
    bit                    func;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
  } line_cmd_t;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_func = 1'b0;
  logic [COORD_BITS-1:0] in_start_x = '0;
  logic [COORD_BITS-1:0] in_start_y = '0;
  logic [COORD_BITS-1:0] in_end_x = '0;
  logic [COORD_BITS-1:0] in_end_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COORD_BITS-1:0] out_point_x;
  logic [COORD_BITS-1:0] out_point_y;
  logic                  out_last;

  line_cmd_t pending_cmds[$];
  pixel_t    expected_pixels[$];
  int        error_count = 0;
  bit        in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_go = 1'b0;
  bit        hold_seen = 1'b0;
  int        hold_len = 0;
  int        hold_left = 0;
  int        live_items = 0;
  int        gen_left = 0;

  // line tracker state
  logic signed [POS_W-1:0]  ln_pos_x = '0;
  logic signed [POS_W-1:0]  ln_pos_y = '0;
  logic signed [STEP_W-1:0] ln_step_x = '0;
  logic signed [STEP_W-1:0] ln_step_y = '0;
  logic [COORD_BITS-1:0]    ln_left = '0;
  bit                       ln_active = 1'b0;

  dda_line_rasterizer_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_last    (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dda_line_rasterizer_unit verification failed");
    $finish;
  end

  function automatic longint slope_of(input longint d, input longint steps);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = (mag << FRAC_BITS) / steps;
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic [COORD_BITS-1:0] pixel_of(input logic signed [POS_W-1:0] p);
    longint v;
    v = p;
    if (v < 0) v = 0;
    return COORD_BITS'((v + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
  endfunction

  task automatic expect_pixel(input bit last);
    pixel_t px;
    px.x = pixel_of(ln_pos_x);
    px.y = pixel_of(ln_pos_y);
    px.last = last;
    expected_pixels.push_back(px);
  endtask

  task automatic trace_line(input line_cmd_t c);
    longint dx;
    longint dy;
    longint adx;
    longint ady;
    longint steps;
    if (c.func == FUNC_LOAD) begin
      dx = longint'(c.ex) - longint'(c.sx);
      dy = longint'(c.ey) - longint'(c.sy);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      steps = (adx > ady) ? adx : ady;
      ln_pos_x = POS_W'(longint'(c.sx) << FRAC_BITS);
      ln_pos_y = POS_W'(longint'(c.sy) << FRAC_BITS);
      if (steps == 0) begin
        ln_step_x = '0;
        ln_step_y = '0;
        ln_left = '0;
        ln_active = 1'b0;
        expect_pixel(1'b1);
      end else begin
        ln_step_x = STEP_W'(slope_of(dx, steps));
        ln_step_y = STEP_W'(slope_of(dy, steps));
        ln_left = COORD_BITS'(steps);
        ln_active = 1'b1;
        expect_pixel(1'b0);
      end
    end else if (ln_active) begin
      ln_pos_x = ln_pos_x + ln_step_x;
      ln_pos_y = ln_pos_y + ln_step_y;
      ln_left = ln_left - 1'b1;
      if (ln_left == 0) ln_active = 1'b0;
      expect_pixel(ln_left == 0);
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic push_next();
    line_cmd_t c;
    c.func = FUNC_NEXT;
    c.sx = COORD_BITS'($urandom);
    c.sy = COORD_BITS'($urandom);
    c.ex = COORD_BITS'($urandom);
    c.ey = COORD_BITS'($urandom);
    pending_cmds.push_back(c);
    if (gen_left > 0) begin
      live_items++;
      gen_left--;
    end
  endtask

  task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                            input int nexts);
    line_cmd_t c;
    int adx;
    int ady;
    c.func = FUNC_LOAD;
    c.sx = COORD_BITS'(sx);
    c.sy = COORD_BITS'(sy);
    c.ex = COORD_BITS'(ex);
    c.ey = COORD_BITS'(ey);
    pending_cmds.push_back(c);
    live_items++;
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    gen_left = (adx > ady) ? adx : ady;
    for (int i = 0; i < nexts; i++) push_next();
  endtask

  task automatic queue_random_lines(input int budget);
    int target;
    int r;
    int sx;
    int sy;
    int ex;
    int ey;
    int steps;
    int n;
    target = live_items + budget;
    while (live_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) push_next();
      end else begin
        sx = $urandom_range(0, COORD_MAX);
        sy = $urandom_range(0, COORD_MAX);
        if (r < 9) begin
          ex = sx;
          ey = sy;
        end else if (r < 12) begin
          ex = $urandom_range(0, COORD_MAX);
          ey = $urandom_range(0, COORD_MAX);
        end else begin
          ex = sx + $urandom_range(0, 24) - 12;
          ey = sy + $urandom_range(0, 24) - 12;
          if (ex < 0 || ex > COORD_MAX) ex = 2 * sx - ex;
          if (ey < 0 || ey > COORD_MAX) ey = 2 * sy - ey;
        end
        steps = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > steps) steps = (ey > sy) ? ey - sy : sy - ey;
        r = $urandom_range(0, 99);
        if (steps > 300) n = $urandom_range(0, 40);
        else if (r < 80) n = steps;
        else if (r < 90) n = steps + $urandom_range(1, 3);
        else n = $urandom_range(0, steps);
        queue_line(sx, sy, ex, ey, n);
      end
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || (in_valid && !in_taken) ||
           expected_pixels.size() != 0);
    @(posedge clk);
  endtask

  task automatic want_left_report();
    pixel_t px;
    px = expected_pixels.pop_front();
    flag_mismatch($sformatf("point (%0d,%0d) last=%0b never arrived", px.x, px.y, px.last));
  endtask

  // source side
  always @(negedge clk) begin : drive
    line_cmd_t c;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
        c = pending_cmds.pop_front();
        in_valid   <= 1'b1;
        in_func    <= c.func;
        in_start_x <= c.sx;
        in_start_y <= c.sy;
        in_end_x   <= c.ex;
        in_end_y   <= c.ey;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // sink side, with the long hold-off counted here
  always @(negedge clk) begin : receive
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  always @(posedge clk) begin : observe
    pixel_t want;
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      trace_line('{in_func, in_start_x, in_start_y, in_end_x, in_end_y});
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        flag_mismatch($sformatf("point (%0d,%0d) last=%0b with none expected",
                                out_point_x, out_point_y, out_last));
      end else begin
        want = expected_pixels.pop_front();
        if (out_point_x !== want.x)
          flag_mismatch($sformatf("point_x %0d, expected %0d", out_point_x, want.x));
        if (out_point_y !== want.y)
          flag_mismatch($sformatf("point_y %0d, expected %0d", out_point_y, want.y));
        if (out_last !== want.last)
          flag_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
      end
    end
  end

  initial begin : sequencer
    int idle_mix[4];
    int stall_mix[4];
    idle_mix = '{0, 63, 0, 38};
    stall_mix = '{0, 0, 63, 38};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_next();
    queue_line(0, 0, 0, 0, 0);
    queue_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
    queue_line(0, 0, COORD_MAX, COORD_MAX, 3);
    queue_line(COORD_MAX, 0, 0, COORD_MAX, 3);
    queue_line(0, COORD_MAX, 3, COORD_MAX - 3, 4);
    queue_line(5, 5, 1, 7, 4);
    queue_line(512, 0, 512, 2, 2);
    queue_line(682, 341, 340, 685, 2);
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      queue_random_lines(325);
      wait_drain();
    end

    // sink held off while the source keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 400;
    hold_go = ~hold_go;
    queue_random_lines(325);
    wait_drain();

    repeat (50) @(posedge clk);
    while (expected_pixels.size() != 0) begin
      want_left_report();
    end
    if (error_count == 0) begin
      $display("dda_line_rasterizer_unit verification clean");
    end else begin
      $display("dda_line_rasterizer_unit verification failed");
    end
    $finish;
  end

endmodule
